@@ src/two_probe_hash_cache_lookup_assert.svh @@
// Assertion macros for the two-probe hash cache lookup.
// Used by the top level only; the bodies are empty in synthesis builds.
`ifndef TWO_PROBE_HASH_CACHE_LOOKUP_ASSERT_SVH
`define TWO_PROBE_HASH_CACHE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TPHCL_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);
// Next-cycle implication.
`define TPHCL_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);
`else
`define TPHCL_ASSERT_NOW(label, clk, rst_n, cond, expr, msg)
`define TPHCL_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

@@ src/tphcl_pkg.sv @@
// Shared types and constants for the two-probe hash cache lookup.
// No dependencies; every other file but the assertion header uses this package.
`default_nettype none
package tphcl_pkg;

	// Multiplier that derives the secondary probe from the hash.
	localparam int unsigned SECOND_MULT = 37;
	// Width of the reported slot index.
	localparam int unsigned SLOT_OUT_W = 10;
	// Depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One lookup request word.
	typedef struct packed {
		logic [31:0] hash_value;
		logic [63:0] lookup_key;
	} in_word_t;

	// One lookup result word.
	typedef struct packed {
		logic                  hit;
		logic                  probe_used;
		logic [SLOT_OUT_W-1:0] slot_index;
	} out_word_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_FETCH,
		BK_RESOLVE
	} back_state_t;

endpackage
`default_nettype wire

@@ src/tphcl_queue.sv @@
// Small register queue that decouples the front end from the back end.
// Depends on tphcl_pkg for its depth.
`default_nettype none
module tphcl_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  full,
	output logic                  empty
);
	localparam int unsigned DEPTH = tphcl_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Storage is written only on a push.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/tphcl_front.sv @@
// Front end: accepts lookup words and works out both probe slots and the key.
// Depends on tphcl_pkg for the request type and the probe multiplier.
`default_nettype none
module tphcl_front #(
	parameter int unsigned ENTRIES  = 1024,
	parameter int unsigned KEY_BITS = 64
) (
	input  wire logic                  start,
	input  wire tphcl_pkg::in_word_t   request,
	input  wire logic                  queue_full,
	input  wire logic                  clearing,
	output logic                       busy,
	output logic                       push,
	output logic [KEY_BITS+2*$clog2(ENTRIES)-1:0] push_data
);
	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] SLOT_MASK = IDX_W'(ENTRIES - 1);

	logic [IDX_W-1:0]    hash_lo;
	logic [IDX_W+5:0]    sec_prod;
	logic [IDX_W-1:0]    pri_slot;
	logic [IDX_W-1:0]    sec_slot;
	logic [KEY_BITS-1:0] key;

	// Words are taken whenever the queue has room and the table is ready.
	assign busy = clearing || queue_full;
	assign push = start && !busy;

	// Only the low slot bits of the hash product matter after masking.
	assign hash_lo  = request.hash_value[IDX_W-1:0];
	assign sec_prod = (IDX_W+6)'(hash_lo) * (IDX_W+6)'(tphcl_pkg::SECOND_MULT);
	assign pri_slot = hash_lo & SLOT_MASK;
	assign sec_slot = sec_prod[IDX_W-1:0] & SLOT_MASK;
	assign key      = request.lookup_key[KEY_BITS-1:0];

	assign push_data = {key, sec_slot, pri_slot};

endmodule
`default_nettype wire

@@ src/tphcl_back.sv @@
// Back end: clears the table after reset, probes both slots, fills on a miss.
// Depends on tphcl_pkg for the result type and the sequencer states.
`default_nettype none
module tphcl_back #(
	parameter int unsigned ENTRIES    = 1024,
	parameter int unsigned KEY_BITS   = 64,
	parameter int unsigned STAMP_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  queue_empty,
	input  wire logic [KEY_BITS+2*$clog2(ENTRIES)-1:0] queue_data,
	output logic                       pop,
	output logic                       clearing,
	output logic                       done,
	output tphcl_pkg::out_word_t       result
);
	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned ROW_W = 1 + KEY_BITS + STAMP_BITS;

	tphcl_pkg::back_state_t state_q;
	tphcl_pkg::back_state_t state_d;

	// Table memory: valid bit, key and stamp in one row.
	logic [ROW_W-1:0]      mem [ENTRIES];
	logic [ROW_W-1:0]      row_a_q;
	logic [ROW_W-1:0]      row_b_q;

	logic [IDX_W-1:0]      clr_idx_q;
	logic [STAMP_BITS-1:0] counter_q;
	logic [IDX_W-1:0]      pri_s1;
	logic [IDX_W-1:0]      sec_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic                  done_q;
	tphcl_pkg::out_word_t  result_q;

	logic [IDX_W-1:0]      q_pri;
	logic [IDX_W-1:0]      q_sec;
	logic [KEY_BITS-1:0]   q_key;

	logic                  va;
	logic                  vb;
	logic [KEY_BITS-1:0]   ka;
	logic [KEY_BITS-1:0]   kb;
	logic [STAMP_BITS-1:0] sa;
	logic [STAMP_BITS-1:0] sb;
	logic                  hit_a;
	logic                  hit_b;
	logic                  res_hit;
	logic                  res_probe;
	logic [IDX_W-1:0]      res_slot;
	logic [STAMP_BITS-1:0] next_stamp;

	logic                  resolve;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [ROW_W-1:0]      mem_wdata;

	assign q_pri = queue_data[IDX_W-1:0];
	assign q_sec = queue_data[2*IDX_W-1:IDX_W];
	assign q_key = queue_data[KEY_BITS+2*IDX_W-1:2*IDX_W];

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tphcl_pkg::BK_CLEAR: begin
				if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
					state_d = tphcl_pkg::BK_FETCH;
				end
			end
			tphcl_pkg::BK_FETCH: begin
				if (!queue_empty) begin
					state_d = tphcl_pkg::BK_RESOLVE;
				end
			end
			tphcl_pkg::BK_RESOLVE: begin
				state_d = tphcl_pkg::BK_FETCH;
			end
			default: begin
				state_d = tphcl_pkg::BK_CLEAR;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		clearing = 1'b0;
		pop      = 1'b0;
		resolve  = 1'b0;
		case (state_q)
			tphcl_pkg::BK_CLEAR:   clearing = 1'b1;
			tphcl_pkg::BK_FETCH:   pop      = !queue_empty;
			tphcl_pkg::BK_RESOLVE: resolve  = 1'b1;
			default:               clearing = 1'b1;
		endcase
	end

	// Compare both probe rows; the primary slot wins hits and stamp ties.
	always_comb begin
		va         = row_a_q[ROW_W-1];
		vb         = row_b_q[ROW_W-1];
		ka         = row_a_q[ROW_W-2 -: KEY_BITS];
		kb         = row_b_q[ROW_W-2 -: KEY_BITS];
		sa         = row_a_q[STAMP_BITS-1:0];
		sb         = row_b_q[STAMP_BITS-1:0];
		hit_a      = va && (ka == key_s1);
		hit_b      = vb && (kb == key_s1);
		next_stamp = counter_q + 1'b1;
		if (hit_a) begin
			res_hit   = 1'b1;
			res_probe = 1'b0;
			res_slot  = pri_s1;
		end else if (hit_b) begin
			res_hit   = 1'b1;
			res_probe = 1'b1;
			res_slot  = sec_s1;
		end else if (sb < sa) begin
			res_hit   = 1'b0;
			res_probe = 1'b1;
			res_slot  = sec_s1;
		end else begin
			res_hit   = 1'b0;
			res_probe = 1'b0;
			res_slot  = pri_s1;
		end
	end

	// Write port: clearing sweep, or a fill on a miss.
	always_comb begin
		if (clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = resolve && !res_hit;
			mem_waddr = res_slot;
			mem_wdata = {1'b1, key_s1, next_stamp};
		end
	end

	// Table memory with one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			row_a_q <= mem[q_pri];
			row_b_q <= mem[q_sec];
		end
	end

	// Request fields held for the compare cycle.
	always_ff @(posedge clk) begin
		if (pop) begin
			pri_s1 <= q_pri;
			sec_s1 <= q_sec;
			key_s1 <= q_key;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (resolve) begin
			result_q.hit        <= res_hit;
			result_q.probe_used <= res_probe;
			result_q.slot_index <= tphcl_pkg::SLOT_OUT_W'(res_slot);
		end
	end

	// Control state: sequencer, sweep index, insertion counter, strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tphcl_pkg::BK_CLEAR;
			clr_idx_q <= '0;
			counter_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= resolve;
			if (clearing) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (resolve && !res_hit) begin
				counter_q <= next_stamp;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

@@ src/two_probe_hash_cache_lookup.sv @@
// Top level of the two-probe hash cache lookup.
// Depends on tphcl_pkg, tphcl_front, tphcl_queue, tphcl_back and the assertion header.
//
// After reset the block sweeps the table to clear every entry, one slot per
// clock, and holds busy high during the sweep. From then on a request word is
// taken at each edge where start is high and busy low. Its result word appears
// with done for one cycle. The word passes through the queue, the two row
// registers of the table read and the result register, and may wait in the
// queue while the back end works on earlier words; up to two words wait there.
// The receiver cannot stall, so results are never held. Busy is also high while
// the two-entry queue is full. Each lookup first reads both probe slots through
// the two read ports (BK_FETCH), then compares and writes back on a miss
// (BK_RESOLVE). The back end takes no new word from the queue until it has
// resolved the last one.
`default_nettype none
`include "two_probe_hash_cache_lookup_assert.svh"
module two_probe_hash_cache_lookup #(
	parameter int unsigned ENTRIES    = 1024,
	parameter int unsigned KEY_BITS   = 64,
	parameter int unsigned STAMP_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire tphcl_pkg::in_word_t  request,
	output logic                      busy,
	output logic                      done,
	output tphcl_pkg::out_word_t      result
);
	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned Q_W   = KEY_BITS + 2 * IDX_W;

	logic           push;
	logic [Q_W-1:0] push_data;
	logic           pop;
	logic [Q_W-1:0] pop_data;
	logic           queue_full;
	logic           queue_empty;
	logic           clearing;

	// Accept and slot calculation.
	tphcl_front #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_front (
		.start      (start),
		.request    (request),
		.queue_full (queue_full),
		.clearing   (clearing),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data)
	);

	// Decoupling queue.
	tphcl_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// Table probe and fill.
	tphcl_back #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_data  (pop_data),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.result      (result)
	);

	// Checks on the interplay of front, queue and back.
	`TPHCL_ASSERT_NOW(a_busy_while_clear, clk, arst_n, clearing, busy, "clear sweep not busy")
	`TPHCL_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !queue_full, "word pushed into full queue")
	`TPHCL_ASSERT_NEXT(a_done_spaced, clk, arst_n, done, !done, "results closer than two cycles")
	`TPHCL_ASSERT_NOW(a_no_done_clear, clk, arst_n, clearing, !done && !pop, "table used while clearing")

endmodule
`default_nettype wire
